// ===== hw/rtl/cst_pkg.sv =====
// shared types, constants and helpers for the config script tokenizer
package cst_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int FIELD_BITS  = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [FIELD_BITS-1:0]  FIELD_MAX  = '1;

  typedef enum logic [3:0] {
    TOK_EOF     = 4'd0,
    TOK_NEWLINE = 4'd1,
    TOK_HASH    = 4'd2,
    TOK_COLON   = 4'd3,
    TOK_LBRACE  = 4'd4,
    TOK_RBRACE  = 4'd5,
    TOK_LPAREN  = 4'd6,
    TOK_RPAREN  = 4'd7,
    TOK_COMMA   = 4'd8,
    TOK_STRING  = 4'd9,
    TOK_NUMBER  = 4'd10,
    TOK_IDENT   = 4'd11,
    TOK_ERROR   = 4'd12
  } tok_type_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    tok_type_t             ttype;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] len;
    logic [FIELD_BITS-1:0] line;
    logic                  last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } scan_res_t;

  function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [OFFSET_BITS-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > 33'(FIELD_MAX)) begin
      return FIELD_MAX;
    end
    return FIELD_BITS'(wide);
  endfunction

endpackage

// ===== hw/rtl/cst_scan.sv =====
// scanner state and per-byte token decision
module cst_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              eot,
  output cst_pkg::scan_res_t res
);
  import cst_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_MINUS, M_INT, M_FRAC, M_IDENT, M_STRING, M_ENDED
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [FIELD_BITS-1:0]  line_r, line_nxt;

  logic is_end, is_dig, is_let;
  logic [OFFSET_BITS-1:0] span_v;

  // dispatch of a byte with no token in progress
  logic                   d_emit, d_set, d_line_inc;
  tok_type_t              d_type;
  logic [FIELD_BITS-1:0]  d_len;
  mode_t                  d_mode;
  logic [OFFSET_BITS-1:0] d_start;

  // pending token closed by this byte
  logic                   p_emit, go;
  tok_type_t              p_type;
  logic [FIELD_BITS-1:0]  p_start, p_len;
  mode_t                  m_mode;

  tok_t t_pend, t_disp;

  assign is_end = eot || (ch == CH_NUL);
  assign is_dig = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_let = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A))
                  || (ch == CH_UNDER);
  assign span_v = (offset_r >= start_r) ? (offset_r - start_r) : '0;

  always_comb begin
    d_emit     = 1'b0;
    d_set      = 1'b0;
    d_line_inc = 1'b0;
    d_type     = TOK_ERROR;
    d_len      = FIELD_BITS'(1);
    d_mode     = M_IDLE;
    d_start    = offset_r;
    if (is_end) begin
      d_emit = 1'b1;
      d_type = TOK_EOF;
      d_len  = '0;
      d_mode = M_ENDED;
    end else begin
      case (ch)
        CH_SPACE, CH_TAB, CH_CR: begin
        end
        CH_LF: begin
          d_emit     = 1'b1;
          d_type     = TOK_NEWLINE;
          d_line_inc = 1'b1;
        end
        CH_HASH: begin
          d_emit = 1'b1;
          d_type = TOK_HASH;
        end
        CH_COLON: begin
          d_emit = 1'b1;
          d_type = TOK_COLON;
        end
        CH_LBRACE: begin
          d_emit = 1'b1;
          d_type = TOK_LBRACE;
        end
        CH_RBRACE: begin
          d_emit = 1'b1;
          d_type = TOK_RBRACE;
        end
        CH_LPAREN: begin
          d_emit = 1'b1;
          d_type = TOK_LPAREN;
        end
        CH_RPAREN: begin
          d_emit = 1'b1;
          d_type = TOK_RPAREN;
        end
        CH_COMMA: begin
          d_emit = 1'b1;
          d_type = TOK_COMMA;
        end
        CH_QUOTE: begin
          // string body starts after the quote
          d_set   = 1'b1;
          d_mode  = M_STRING;
          d_start = (offset_r < OFFSET_MAX) ? offset_r + OFFSET_BITS'(1) : offset_r;
        end
        CH_SLASH: begin
          d_set  = 1'b1;
          d_mode = M_SLASH;
        end
        CH_MINUS: begin
          d_set  = 1'b1;
          d_mode = M_MINUS;
        end
        default: begin
          if (is_dig) begin
            d_set  = 1'b1;
            d_mode = M_INT;
          end else if (is_let) begin
            d_set  = 1'b1;
            d_mode = M_IDENT;
          end else begin
            d_emit = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    p_emit  = 1'b0;
    go      = 1'b0;
    p_type  = TOK_ERROR;
    p_start = clamp_field(start_r);
    p_len   = FIELD_BITS'(1);
    m_mode  = mode_r;
    case (mode_r)
      M_IDLE: go = 1'b1;
      M_ENDED: begin
        p_emit  = 1'b1;
        p_type  = TOK_EOF;
        p_start = clamp_field(offset_r);
        p_len   = '0;
      end
      M_SLASH: begin
        if (!is_end && ch == CH_SLASH) begin
          m_mode = M_COMMENT;
        end else begin
          p_emit = 1'b1;
          go     = 1'b1;
        end
      end
      M_COMMENT: go = is_end || (ch == CH_LF);
      M_MINUS: begin
        if (!is_end && is_dig) begin
          m_mode = M_INT;
        end else begin
          p_emit = 1'b1;
          go     = 1'b1;
        end
      end
      M_INT: begin
        if (!is_end && ch == CH_DOT) begin
          m_mode = M_FRAC;
        end else if (is_end || !is_dig) begin
          p_emit = 1'b1;
          p_type = TOK_NUMBER;
          p_len  = clamp_field(span_v);
          go     = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_end || !is_dig) begin
          p_emit = 1'b1;
          p_type = TOK_NUMBER;
          p_len  = clamp_field(span_v);
          go     = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_end || !(is_let || is_dig || ch == CH_DOT)) begin
          p_emit = 1'b1;
          p_type = TOK_IDENT;
          p_len  = clamp_field(span_v);
          go     = 1'b1;
        end
      end
      M_STRING: begin
        if (is_end) begin
          p_emit = 1'b1;
          p_type = TOK_STRING;
          p_len  = clamp_field(span_v);
          go     = 1'b1;
        end else if (ch == CH_QUOTE) begin
          // closing quote ends the string with nothing left to scan
          p_emit = 1'b1;
          p_type = TOK_STRING;
          p_len  = clamp_field(span_v);
          m_mode = M_IDLE;
        end
      end
      default: go = 1'b1;
    endcase
  end

  always_comb begin
    logic disp_emit;
    disp_emit = go && d_emit;

    t_pend.ttype = p_type;
    t_pend.start = p_start;
    t_pend.len   = p_len;
    t_pend.line  = line_r;
    t_pend.last  = !disp_emit;

    t_disp.ttype = d_type;
    t_disp.start = clamp_field(offset_r);
    t_disp.len   = d_len;
    t_disp.line  = line_r;
    t_disp.last  = 1'b1;

    res.count = {1'b0, p_emit} + {1'b0, disp_emit};
    res.tok0  = p_emit ? t_pend : t_disp;
    res.tok1  = t_disp;

    mode_nxt   = go ? d_mode : m_mode;
    start_nxt  = (go && d_set) ? d_start : start_r;
    line_nxt   = (go && d_line_inc && line_r != FIELD_MAX) ? line_r + FIELD_BITS'(1) : line_r;
    offset_nxt = (!is_end && mode_r != M_ENDED && offset_r != OFFSET_MAX)
                 ? offset_r + OFFSET_BITS'(1) : offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      offset_r <= '0;
      start_r  <= '0;
      line_r   <= FIELD_BITS'(1);
    end else if (step) begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

// ===== hw/rtl/config_script_tokenizer.sv =====
// top level of the config script tokenizer: input register, scanner, result queue
//
// usage:
//   in_*  : one request per source byte; in_tdata holds the byte, in_tuser
//           flags end of text (a byte of zero also ends the text)
//   out_* : one request per token; out_tuser holds the token type, out_tdata
//           holds start offset, length and line number, out_tlast marks the
//           final token caused by one input request
// path: a request taken in sits in the input register while the scanner decides its
//   tokens, which are written into the result queue once all of them fit; the first
//   token is shown from the head of the queue and can be taken there
// throughput: one byte per cycle while the result queue has room; a byte that closes a
//   pending token and makes a token of its own yields two tokens, and the output side
//   then sets the pace at one token per cycle
// the two-entry result queue decouples the sides: the input register keeps
//   taking bytes while a token waits, and stalls only when the queue lacks
//   room for the tokens of the byte it holds
// reset clears the scanner to idle, offset 0, line 1, and empties both stages
// after end of text every later request yields one eof token at the frozen
//   offset until reset
module config_script_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] start_res, [31:16] length, [47:32] line
  output logic [3:0]  out_tuser,  // [3:0] token_type
  output logic        out_tlast   // last_of_run
);
  import cst_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_eot_r;
  logic       s1_move;

  // result queue, entry 0 is the head
  tok_t       q_r   [2];
  tok_t       q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] base_cnt;
  logic [2:0] room;

  scan_res_t  res;

  cst_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .ch    (s1_ch_r),
    .eot   (s1_eot_r),
    .res   (res)
  );

  assign pop      = out_tvalid && out_tready;
  assign base_cnt = cnt_r - {1'b0, pop};
  assign room     = 3'd2 - {1'b0, base_cnt};
  // the byte moves on only when all of its tokens fit
  assign s1_move  = s1_valid_r && ({1'b0, res.count} <= room);
  assign in_tready = !s1_valid_r || s1_move;

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = base_cnt;
    if (s1_move) begin
      cnt_nxt = base_cnt + res.count;
      if (res.count != 2'd0) begin
        q_nxt[base_cnt[0]] = res.tok0;
      end
      if (res.count == 2'd2) begin
        q_nxt[1] = res.tok1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ch_r  <= in_tdata;
      s1_eot_r <= in_tuser;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {q_r[0].line, q_r[0].len, q_r[0].start};
  assign out_tuser  = q_r[0].ttype;
  assign out_tlast  = q_r[0].last;

endmodule
